// ===== hdl/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and codes for the format specifier parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

  typedef enum logic [2:0] {
    PH_SCAN  = 3'd0,
    PH_FLAGS = 3'd1,
    PH_WIDTH = 3'd2,
    PH_DOT   = 3'd3,
    PH_PREC  = 3'd4,
    PH_LEN_L = 3'd5,
    PH_LEN_H = 3'd6,
    PH_CONV  = 3'd7
  } phase_t;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_HH   = 3'd1;
  localparam logic [2:0] LEN_H    = 3'd2;
  localparam logic [2:0] LEN_L    = 3'd3;
  localparam logic [2:0] LEN_LL   = 3'd4;

  localparam int FLAG_ALT   = 0;
  localparam int FLAG_SPACE = 1;
  localparam int FLAG_LEFT  = 2;
  localparam int FLAG_PLUS  = 3;
  localparam int FLAG_ZERO  = 4;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_LOW_L   = 8'h6c;
  localparam logic [7:0] CH_LOW_H   = 8'h68;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  flags;
    logic        width_seen;
    logic        prec_seen;
    logic [2:0]  length;
  } ctrl_t;

  typedef struct packed {
    logic        is_end;
    logic        alt_form;
    logic        space_sign;
    logic        left_justify;
    logic        show_sign;
    logic        pad_zero;
    logic        has_width;
    logic [15:0] width_value;
    logic        has_precision;
    logic [15:0] precision_value;
    logic [2:0]  length_mod;
    logic [7:0]  conversion;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/fsp_step.sv =====
// ----------------------------------------------------------------------------
// fsp_step
// Next-state and result logic for one format byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_step #(
  parameter int NUM_BITS = 16
) (
  input  wire logic [7:0]          ch,
  input  wire fsp_pkg::ctrl_t      st,
  input  wire logic [NUM_BITS-1:0] width_acc,
  input  wire logic [NUM_BITS-1:0] prec_acc,
  output fsp_pkg::ctrl_t           st_next,
  output logic [NUM_BITS-1:0]      width_next,
  output logic [NUM_BITS-1:0]      prec_next,
  output logic                     emit,
  output fsp_pkg::result_t         res
);

  localparam logic [NUM_BITS-1:0] CountMax = {NUM_BITS{1'b1}};

  function automatic logic [NUM_BITS-1:0] accum(input logic [NUM_BITS-1:0] acc,
                                                input logic [7:0] c);
    logic [NUM_BITS+3:0] wide;
    logic [NUM_BITS+3:0] sum;
    wide = {4'd0, acc};
    sum  = (wide << 3) + (wide << 1) + {{NUM_BITS{1'b0}}, c[3:0]};
    if (sum > {4'd0, CountMax}) begin
      return CountMax;
    end
    return sum[NUM_BITS-1:0];
  endfunction

  function automatic logic [15:0] low16(input logic [NUM_BITS-1:0] v);
    logic [NUM_BITS+15:0] ext;
    ext = {16'd0, v};
    return ext[15:0];
  endfunction

  logic       digit;
  logic       blank;
  logic       is_end;
  logic [7:0] conv;
  logic [2:0] len;
  logic       tail;

  assign digit = (ch >= fsp_pkg::CH_ZERO) && (ch <= fsp_pkg::CH_NINE);

  always_comb begin
    st_next    = st;
    width_next = width_acc;
    prec_next  = prec_acc;
    emit       = 1'b0;
    blank      = 1'b0;
    is_end     = 1'b0;
    conv       = fsp_pkg::CH_NUL;
    len        = st.length;
    tail       = 1'b0;

    if (st.phase == fsp_pkg::PH_SCAN) begin
      if (ch == fsp_pkg::CH_NUL) begin
        emit   = 1'b1;
        blank  = 1'b1;
        is_end = 1'b1;
      end else if (ch == fsp_pkg::CH_PERCENT) begin
        st_next.phase = fsp_pkg::PH_FLAGS;
      end
    end else if (ch == fsp_pkg::CH_NUL) begin
      emit   = 1'b1;
      is_end = 1'b1;
    end else begin
      unique case (st.phase)
        fsp_pkg::PH_FLAGS: begin
          priority if (ch == fsp_pkg::CH_HASH) begin
            st_next.flags[fsp_pkg::FLAG_ALT] = 1'b1;
          end else if (ch == fsp_pkg::CH_SPACE) begin
            st_next.flags[fsp_pkg::FLAG_SPACE] = 1'b1;
          end else if (ch == fsp_pkg::CH_MINUS) begin
            st_next.flags[fsp_pkg::FLAG_LEFT] = 1'b1;
          end else if (ch == fsp_pkg::CH_PLUS) begin
            st_next.flags[fsp_pkg::FLAG_PLUS] = 1'b1;
          end else if (ch == fsp_pkg::CH_ZERO) begin
            st_next.flags[fsp_pkg::FLAG_ZERO] = 1'b1;
          end else if (digit) begin
            st_next.width_seen = 1'b1;
            width_next         = accum('0, ch);
            st_next.phase      = fsp_pkg::PH_WIDTH;
          end else if (ch == fsp_pkg::CH_DOT) begin
            st_next.phase = fsp_pkg::PH_DOT;
          end else begin
            tail = 1'b1;
          end
        end
        fsp_pkg::PH_WIDTH: begin
          priority if (digit) begin
            width_next = accum(width_acc, ch);
          end else if (ch == fsp_pkg::CH_DOT) begin
            st_next.phase = fsp_pkg::PH_DOT;
          end else begin
            tail = 1'b1;
          end
        end
        fsp_pkg::PH_DOT: begin
          if (digit) begin
            st_next.prec_seen = 1'b1;
            prec_next         = accum('0, ch);
            st_next.phase     = fsp_pkg::PH_PREC;
          end else begin
            tail = 1'b1;
          end
        end
        fsp_pkg::PH_PREC: begin
          if (digit) begin
            prec_next = accum(prec_acc, ch);
          end else begin
            tail = 1'b1;
          end
        end
        fsp_pkg::PH_LEN_L: begin
          if (ch == fsp_pkg::CH_LOW_L) begin
            st_next.length = fsp_pkg::LEN_LL;
            st_next.phase  = fsp_pkg::PH_CONV;
          end else begin
            len  = fsp_pkg::LEN_L;
            emit = 1'b1;
            conv = ch;
          end
        end
        fsp_pkg::PH_LEN_H: begin
          if (ch == fsp_pkg::CH_LOW_H) begin
            st_next.length = fsp_pkg::LEN_HH;
            st_next.phase  = fsp_pkg::PH_CONV;
          end else begin
            len  = fsp_pkg::LEN_H;
            emit = 1'b1;
            conv = ch;
          end
        end
        fsp_pkg::PH_CONV: begin
          emit = 1'b1;
          conv = ch;
        end
        fsp_pkg::PH_SCAN: begin
          st_next = st;
        end
      endcase

      if (tail) begin
        priority if (ch == fsp_pkg::CH_LOW_L) begin
          st_next.phase = fsp_pkg::PH_LEN_L;
        end else if (ch == fsp_pkg::CH_LOW_H) begin
          st_next.phase = fsp_pkg::PH_LEN_H;
        end else begin
          emit = 1'b1;
          conv = ch;
        end
      end
    end

    res.is_end          = is_end;
    res.alt_form        = !blank && st.flags[fsp_pkg::FLAG_ALT];
    res.space_sign      = !blank && st.flags[fsp_pkg::FLAG_SPACE];
    res.left_justify    = !blank && st.flags[fsp_pkg::FLAG_LEFT];
    res.show_sign       = !blank && st.flags[fsp_pkg::FLAG_PLUS];
    res.pad_zero        = !blank && st.flags[fsp_pkg::FLAG_ZERO]
                          && !st.flags[fsp_pkg::FLAG_LEFT];
    res.has_width       = !blank && st.width_seen;
    res.width_value     = (!blank && st.width_seen) ? low16(width_acc) : 16'd0;
    res.has_precision   = !blank && st.prec_seen;
    res.precision_value = (!blank && st.prec_seen) ? low16(prec_acc) : 16'd0;
    res.length_mod      = blank ? fsp_pkg::LEN_NONE : len;
    res.conversion      = conv;

    if (emit) begin
      st_next.phase      = fsp_pkg::PH_SCAN;
      st_next.flags      = 5'd0;
      st_next.width_seen = 1'b0;
      st_next.prec_seen  = 1'b0;
      st_next.length     = fsp_pkg::LEN_NONE;
      width_next         = '0;
      prec_next          = '0;
    end else if (st.phase == fsp_pkg::PH_SCAN && ch == fsp_pkg::CH_PERCENT) begin
      st_next.flags      = 5'd0;
      st_next.width_seen = 1'b0;
      st_next.prec_seen  = 1'b0;
      st_next.length     = fsp_pkg::LEN_NONE;
      width_next         = '0;
      prec_next          = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/format_spec_parser.sv =====
// ----------------------------------------------------------------------------
// format_spec_parser
// Printf-style format specifier parser, one format byte per beat.
//
//   channel  direction  handshake          payload
//   input    in         in_valid/in_stall  ch
//   result   out        out_valid/out_stall is_end, flags, width, precision,
//                                          length_mod, conversion
//
// A byte is taken every cycle while in_stall is low; the byte that finishes
// a specifier passes the input register, then the two-entry result queue.
// The parse state is one register update per byte, so the rate is one byte
// per cycle. Reset returns the parser to scanning with all fields cleared.
// in_stall rises only while a byte is held and the result queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module format_spec_parser #(
  parameter int NUM_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  ch,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_end,
  output logic             alt_form,
  output logic             space_sign,
  output logic             left_justify,
  output logic             show_sign,
  output logic             pad_zero,
  output logic             has_width,
  output logic [15:0]      width_value,
  output logic             has_precision,
  output logic [15:0]      precision_value,
  output logic [2:0]       length_mod,
  output logic [7:0]       conversion
);

  logic [7:0]          ch_q;
  logic                ch_valid;
  fsp_pkg::ctrl_t      st;
  fsp_pkg::ctrl_t      st_next;
  logic [NUM_BITS-1:0] width_acc;
  logic [NUM_BITS-1:0] width_next;
  logic [NUM_BITS-1:0] prec_acc;
  logic [NUM_BITS-1:0] prec_next;
  logic                emit;
  fsp_pkg::result_t    res;
  fsp_pkg::result_t    head;
  fsp_pkg::result_t    skid;
  logic                head_valid;
  logic                skid_valid;
  logic                step;
  logic                push;
  logic                pop;

  fsp_step #(
    .NUM_BITS(NUM_BITS)
  ) u_step (
    .ch        (ch_q),
    .st        (st),
    .width_acc (width_acc),
    .prec_acc  (prec_acc),
    .st_next   (st_next),
    .width_next(width_next),
    .prec_next (prec_next),
    .emit      (emit),
    .res       (res)
  );

  assign in_stall  = ch_valid && skid_valid;
  assign step      = ch_valid && !skid_valid;
  assign push      = step && emit;
  assign out_valid = head_valid;
  assign pop       = head_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid      <= 1'b0;
      st.phase      <= fsp_pkg::PH_SCAN;
      st.flags      <= 5'd0;
      st.width_seen <= 1'b0;
      st.prec_seen  <= 1'b0;
      st.length     <= fsp_pkg::LEN_NONE;
      width_acc     <= '0;
      prec_acc      <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        ch_q     <= ch;
        ch_valid <= 1'b1;
      end else if (step) begin
        ch_valid <= 1'b0;
      end
      if (step) begin
        st        <= st_next;
        width_acc <= width_next;
        prec_acc  <= prec_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        head       <= skid;
        skid_valid <= 1'b0;
      end
    end else if (head_valid) begin
      if (pop && push) begin
        head <= res;
      end else if (pop) begin
        head_valid <= 1'b0;
      end else if (push) begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end else if (push) begin
      head       <= res;
      head_valid <= 1'b1;
    end
  end

  assign is_end          = head.is_end;
  assign alt_form        = head.alt_form;
  assign space_sign      = head.space_sign;
  assign left_justify    = head.left_justify;
  assign show_sign       = head.show_sign;
  assign pad_zero        = head.pad_zero;
  assign has_width       = head.has_width;
  assign width_value     = head.width_value;
  assign has_precision   = head.has_precision;
  assign precision_value = head.precision_value;
  assign length_mod      = head.length_mod;
  assign conversion      = head.conversion;

endmodule

`default_nettype wire

// ===== dv/tb_format_spec_parser.sv =====
// ----------------------------------------------------------------------------
// tb_format_spec_parser
// Self-checking bench for the format specifier parser. Format bytes go in
// through the valid/stall channel in random bursts. A parser model in the
// bench works out each spec or end-of-string beat, and every result beat is
// compared field by field, in order, against the model. Directed strings hit
// the flags, length modifiers, saturation, a dot with no digits and NUL inside
// a spec. Random specs and byte noise follow, with result back-pressure that
// changes its pattern and includes one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_format_spec_parser;

  localparam int FMT_BITS = 16;
  localparam longint unsigned SAT_MAX = (64'd1 << FMT_BITS) - 1;
  localparam int IDLE_LIMIT = 1000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] ch = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic is_end;
  logic alt_form;
  logic space_sign;
  logic left_justify;
  logic show_sign;
  logic pad_zero;
  logic has_width;
  logic [15:0] width_value;
  logic has_precision;
  logic [15:0] precision_value;
  logic [2:0] length_mod;
  logic [7:0] conversion;

  fsp_pkg::phase_t fmt_phase = fsp_pkg::PH_SCAN;
  logic [4:0] fmt_flags = '0;
  longint unsigned fmt_width = 0;
  longint unsigned fmt_prec = 0;
  logic fmt_width_seen = 1'b0;
  logic fmt_prec_seen = 1'b0;
  logic [2:0] fmt_len = fsp_pkg::LEN_NONE;

  fsp_pkg::result_t spec_q[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int burst_left = 0;
  int gap_max = 6;
  int holdoff_req = 0;
  int holdoff_left = 0;
  int pattern_left = 0;
  int stall_pct = 0;

  string conv_chars = "diouxXcspfegn%";
  logic [7:0] flag_chars [5] = '{fsp_pkg::CH_HASH, fsp_pkg::CH_SPACE, fsp_pkg::CH_MINUS,
                                 fsp_pkg::CH_PLUS, fsp_pkg::CH_ZERO};

  format_spec_parser #(.NUM_BITS(FMT_BITS)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .ch(ch),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .is_end(is_end),
    .alt_form(alt_form),
    .space_sign(space_sign),
    .left_justify(left_justify),
    .show_sign(show_sign),
    .pad_zero(pad_zero),
    .has_width(has_width),
    .width_value(width_value),
    .has_precision(has_precision),
    .precision_value(precision_value),
    .length_mod(length_mod),
    .conversion(conversion)
  );

  always #2 clk = ~clk;

  function automatic bit is_digit(logic [7:0] c);
    return (c >= fsp_pkg::CH_ZERO) && (c <= fsp_pkg::CH_NINE);
  endfunction

  function automatic longint unsigned add_digit(longint unsigned acc, logic [7:0] c);
    longint unsigned v;
    v = acc * 10 + longint'(c - fsp_pkg::CH_ZERO);
    return (v > SAT_MAX) ? SAT_MAX : v;
  endfunction

  function automatic void clear_spec();
    fmt_flags = '0;
    fmt_width = 0;
    fmt_width_seen = 1'b0;
    fmt_prec = 0;
    fmt_prec_seen = 1'b0;
    fmt_len = fsp_pkg::LEN_NONE;
  endfunction

  function automatic fsp_pkg::result_t finish_spec(logic [7:0] conv, logic at_end);
    fsp_pkg::result_t r;
    r.is_end = at_end;
    r.alt_form = fmt_flags[fsp_pkg::FLAG_ALT];
    r.space_sign = fmt_flags[fsp_pkg::FLAG_SPACE];
    r.left_justify = fmt_flags[fsp_pkg::FLAG_LEFT];
    r.show_sign = fmt_flags[fsp_pkg::FLAG_PLUS];
    r.pad_zero = fmt_flags[fsp_pkg::FLAG_ZERO] & ~fmt_flags[fsp_pkg::FLAG_LEFT];
    r.has_width = fmt_width_seen;
    r.width_value = fmt_width_seen ? fmt_width[15:0] : 16'h0000;
    r.has_precision = fmt_prec_seen;
    r.precision_value = fmt_prec_seen ? fmt_prec[15:0] : 16'h0000;
    r.length_mod = fmt_len;
    r.conversion = conv;
    fmt_phase = fsp_pkg::PH_SCAN;
    clear_spec();
    return r;
  endfunction

  function automatic bit tail_byte(logic [7:0] c, output fsp_pkg::result_t r);
    r = '0;
    if (c == fsp_pkg::CH_LOW_L) begin
      fmt_phase = fsp_pkg::PH_LEN_L;
      return 1'b0;
    end
    if (c == fsp_pkg::CH_LOW_H) begin
      fmt_phase = fsp_pkg::PH_LEN_H;
      return 1'b0;
    end
    r = finish_spec(c, 1'b0);
    return 1'b1;
  endfunction

  // Advance the parser model by one byte; return 1 when a beat is due.
  function automatic bit parse_byte(logic [7:0] c, output fsp_pkg::result_t r);
    r = '0;
    if (fmt_phase == fsp_pkg::PH_SCAN) begin
      if (c == fsp_pkg::CH_NUL) begin
        r.is_end = 1'b1;
        return 1'b1;
      end
      if (c == fsp_pkg::CH_PERCENT) begin
        clear_spec();
        fmt_phase = fsp_pkg::PH_FLAGS;
      end
      return 1'b0;
    end
    if (c == fsp_pkg::CH_NUL) begin
      r = finish_spec(fsp_pkg::CH_NUL, 1'b1);
      return 1'b1;
    end
    case (fmt_phase)
      fsp_pkg::PH_FLAGS: begin
        if (c == fsp_pkg::CH_HASH) fmt_flags[fsp_pkg::FLAG_ALT] = 1'b1;
        else if (c == fsp_pkg::CH_SPACE) fmt_flags[fsp_pkg::FLAG_SPACE] = 1'b1;
        else if (c == fsp_pkg::CH_MINUS) fmt_flags[fsp_pkg::FLAG_LEFT] = 1'b1;
        else if (c == fsp_pkg::CH_PLUS) fmt_flags[fsp_pkg::FLAG_PLUS] = 1'b1;
        else if (c == fsp_pkg::CH_ZERO) fmt_flags[fsp_pkg::FLAG_ZERO] = 1'b1;
        else if (is_digit(c)) begin
          fmt_width_seen = 1'b1;
          fmt_width = add_digit(0, c);
          fmt_phase = fsp_pkg::PH_WIDTH;
        end else if (c == fsp_pkg::CH_DOT) fmt_phase = fsp_pkg::PH_DOT;
        else return tail_byte(c, r);
        return 1'b0;
      end
      fsp_pkg::PH_WIDTH: begin
        if (is_digit(c)) fmt_width = add_digit(fmt_width, c);
        else if (c == fsp_pkg::CH_DOT) fmt_phase = fsp_pkg::PH_DOT;
        else return tail_byte(c, r);
        return 1'b0;
      end
      fsp_pkg::PH_DOT: begin
        if (is_digit(c)) begin
          fmt_prec_seen = 1'b1;
          fmt_prec = add_digit(0, c);
          fmt_phase = fsp_pkg::PH_PREC;
          return 1'b0;
        end
        return tail_byte(c, r);
      end
      fsp_pkg::PH_PREC: begin
        if (is_digit(c)) begin
          fmt_prec = add_digit(fmt_prec, c);
          return 1'b0;
        end
        return tail_byte(c, r);
      end
      fsp_pkg::PH_LEN_L: begin
        if (c == fsp_pkg::CH_LOW_L) begin
          fmt_len = fsp_pkg::LEN_LL;
          fmt_phase = fsp_pkg::PH_CONV;
          return 1'b0;
        end
        fmt_len = fsp_pkg::LEN_L;
        r = finish_spec(c, 1'b0);
        return 1'b1;
      end
      fsp_pkg::PH_LEN_H: begin
        if (c == fsp_pkg::CH_LOW_H) begin
          fmt_len = fsp_pkg::LEN_HH;
          fmt_phase = fsp_pkg::PH_CONV;
          return 1'b0;
        end
        fmt_len = fsp_pkg::LEN_H;
        r = finish_spec(c, 1'b0);
        return 1'b1;
      end
      default: begin
        r = finish_spec(c, 1'b0);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_spec_beat();
    fsp_pkg::result_t want;
    if (spec_q.size() == 0) begin
      report_mismatch("result beat with nothing expected");
      return;
    end
    want = spec_q.pop_front();
    check_field("is_end", 16'(is_end), 16'(want.is_end));
    check_field("alt_form", 16'(alt_form), 16'(want.alt_form));
    check_field("space_sign", 16'(space_sign), 16'(want.space_sign));
    check_field("left_justify", 16'(left_justify), 16'(want.left_justify));
    check_field("show_sign", 16'(show_sign), 16'(want.show_sign));
    check_field("pad_zero", 16'(pad_zero), 16'(want.pad_zero));
    check_field("has_width", 16'(has_width), 16'(want.has_width));
    check_field("width_value", width_value, want.width_value);
    check_field("has_precision", 16'(has_precision), 16'(want.has_precision));
    check_field("precision_value", precision_value, want.precision_value);
    check_field("length_mod", 16'(length_mod), 16'(want.length_mod));
    check_field("conversion", 16'(conversion), 16'(want.conversion));
  endtask

  always @(posedge clk) begin : spec_monitor
    fsp_pkg::result_t next_r;
    if (rst) begin
      fmt_phase = fsp_pkg::PH_SCAN;
      clear_spec();
      spec_q.delete();
    end else begin
      if (out_valid && !out_stall) check_spec_beat();
      if (in_valid && !in_stall) begin
        if (parse_byte(ch, next_r)) spec_q.push_back(next_r);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Hold off on request; otherwise stall at a rate redrawn whenever pattern_left runs out.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req = 0;
      out_stall <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = 64;
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      pattern_left--;
      out_stall <= ($urandom_range(1, 100) <= stall_pct);
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    ch <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (spec_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_digits(int count, bit nonzero_first);
    int i;
    for (i = 0; i < count; i++) begin
      if (i == 0 && nonzero_first) send_byte(fsp_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
      else send_byte(fsp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  function automatic int digit_count();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    return (b == fsp_pkg::CH_PERCENT) ? 8'h41 : b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return fsp_pkg::CH_PERCENT;
      1: return fsp_pkg::CH_NUL;
      2: return fsp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      3: return flag_chars[$urandom_range(0, 4)];
      4: begin
        case ($urandom_range(0, 2))
          0: return fsp_pkg::CH_DOT;
          1: return fsp_pkg::CH_LOW_L;
          default: return fsp_pkg::CH_LOW_H;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_spec();
    int n;
    n = $urandom_range(0, 3);
    repeat (n) send_byte(text_byte());
    send_byte(fsp_pkg::CH_PERCENT);
    n = $urandom_range(0, 3);
    repeat (n) send_byte(flag_chars[$urandom_range(0, 4)]);
    if ($urandom_range(0, 2) != 0) send_digits(digit_count(), 1'b1);
    if ($urandom_range(0, 2) == 0) begin
      send_byte(fsp_pkg::CH_DOT);
      if ($urandom_range(0, 3) != 0) send_digits(digit_count(), 1'b0);
    end
    case ($urandom_range(0, 5))
      1: send_byte(fsp_pkg::CH_LOW_H);
      2: begin
        send_byte(fsp_pkg::CH_LOW_H);
        send_byte(fsp_pkg::CH_LOW_H);
      end
      3: send_byte(fsp_pkg::CH_LOW_L);
      4: begin
        send_byte(fsp_pkg::CH_LOW_L);
        send_byte(fsp_pkg::CH_LOW_L);
      end
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: send_byte(fsp_pkg::CH_NUL);
      1: send_byte(8'($urandom_range(1, 255)));
      default: send_byte(conv_chars[$urandom_range(0, conv_chars.len() - 1)]);
    endcase
  endtask

  task automatic test_end_while_scanning();
    send_byte(fsp_pkg::CH_NUL);
    wait_for_results();
  endtask

  task automatic test_flags_and_length();
    send_text("%#-+ 0lld");
    send_text("%0hh");
    send_byte(8'hff);
    send_text("%%");
    wait_for_results();
  endtask

  task automatic test_width_and_precision();
    send_text("%99999.f");
    send_text("%.7l");
    send_byte(fsp_pkg::CH_NUL);
    wait_for_results();
  endtask

  // Fill the result queue while the receiver holds off, so the input stalls.
  task automatic test_backpressure();
    gap_max = 0;
    holdoff_req = HOLDOFF_CYCLES;
    send_text("%d%x%u%c%s%p%i%o%d%x%u%c%s%p%i%o");
    wait_for_results();
    gap_max = 6;
  endtask

  task automatic test_random_specs();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 650) begin
      if ($urandom_range(0, 15) == 0) gap_max = $urandom_range(0, 1) ? 0 : 12;
      send_random_spec();
    end
    gap_max = 6;
    wait_for_results();
  endtask

  task automatic test_random_noise();
    repeat (250) send_byte(noise_byte());
    wait_for_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_end_while_scanning();
    test_flags_and_length();
    test_width_and_precision();
    test_backpressure();
    test_random_specs();
    test_random_noise();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && spec_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
